/* sv/imu_pkg.sv */
package imu_pkg;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8000000000000;
    localparam logic [63:0] INF_BITS  = 64'h7FF0000000000000;
    localparam logic [63:0] MAXF_BITS = 64'h7FEFFFFFFFFFFFFF;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW = $clog2(Q_DEPTH);
    localparam int unsigned MUL_STAGES = 6;

    // one queued job: two downward and two upward endpoint products
    typedef struct packed {
        logic        both;
        logic [63:0] lo0_a;
        logic [63:0] lo0_b;
        logic [63:0] lo1_a;
        logic [63:0] lo1_b;
        logic [63:0] hi0_a;
        logic [63:0] hi0_b;
        logic [63:0] hi1_a;
        logic [63:0] hi1_b;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic is_nan(input logic [63:0] x);
        return x[62:0] > INF_BITS[62:0];
    endfunction

    function automatic logic ge_zero(input logic [63:0] x);
        return !is_nan(x) && (!x[63] || x[62:0] == '0);
    endfunction

    function automatic logic le_zero(input logic [63:0] x);
        return !is_nan(x) && (x[63] || x[62:0] == '0);
    endfunction

    function automatic logic [63:0] order_key(input logic [63:0] x);
        return x[63] ? ~x : {1'b1, x[62:0]};
    endfunction

    function automatic logic [63:0] fmin_bits(input logic [63:0] a, input logic [63:0] b);
        if (is_nan(a) || is_nan(b)) return QNAN_BITS;
        return (order_key(a) <= order_key(b)) ? a : b;
    endfunction

    function automatic logic [63:0] fmax_bits(input logic [63:0] a, input logic [63:0] b);
        if (is_nan(a) || is_nan(b)) return QNAN_BITS;
        return (order_key(a) >= order_key(b)) ? a : b;
    endfunction

endpackage

/* sv/imu_front.sv */
module imu_front (
    input  logic                 i_valid,
    input  logic [255:0]         i_data,
    input  imu_pkg::t_q_stat     i_q_stat,
    output logic                 o_ready,
    output logic                 o_push,
    output imu_pkg::t_job        o_job
);

    logic [63:0] al, au, bl, bu;
    logic        ag, al0, bg, bl0;

    assign al = i_data[63:0];
    assign au = i_data[127:64];
    assign bl = i_data[191:128];
    assign bu = i_data[255:192];

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    always_comb begin
        ag  = imu_pkg::ge_zero(al);
        al0 = imu_pkg::le_zero(au);
        bg  = imu_pkg::ge_zero(bl);
        bl0 = imu_pkg::le_zero(bu);
        o_job = '0;
        o_job.lo1_a = al;
        o_job.lo1_b = bu;
        o_job.hi1_a = au;
        o_job.hi1_b = bu;
        if (ag) begin
            if (bg) begin
                o_job.lo0_a = al; o_job.lo0_b = bl; o_job.hi0_a = au; o_job.hi0_b = bu;
            end else if (bl0) begin
                o_job.lo0_a = au; o_job.lo0_b = bl; o_job.hi0_a = al; o_job.hi0_b = bu;
            end else begin
                o_job.lo0_a = au; o_job.lo0_b = bl; o_job.hi0_a = au; o_job.hi0_b = bu;
            end
        end else if (al0) begin
            if (bg) begin
                o_job.lo0_a = al; o_job.lo0_b = bu; o_job.hi0_a = au; o_job.hi0_b = bl;
            end else if (bl0) begin
                o_job.lo0_a = au; o_job.lo0_b = bu; o_job.hi0_a = al; o_job.hi0_b = bl;
            end else begin
                o_job.lo0_a = al; o_job.lo0_b = bu; o_job.hi0_a = al; o_job.hi0_b = bl;
            end
        end else begin
            if (bg) begin
                o_job.lo0_a = al; o_job.lo0_b = bu; o_job.hi0_a = au; o_job.hi0_b = bu;
            end else if (bl0) begin
                o_job.lo0_a = au; o_job.lo0_b = bl; o_job.hi0_a = al; o_job.hi0_b = bl;
            end else begin
                o_job.both  = 1'b1;
                o_job.lo0_a = au; o_job.lo0_b = bl; o_job.hi0_a = al; o_job.hi0_b = bl;
            end
        end
    end

endmodule

/* sv/imu_fifo.sv */
module imu_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  imu_pkg::t_job     i_job,
    input  logic              i_pop,
    output imu_pkg::t_job     o_job,
    output imu_pkg::t_q_stat  o_stat
);

    imu_pkg::t_job r_mem [imu_pkg::Q_DEPTH];
    logic [imu_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [imu_pkg::Q_AW:0]   r_cnt;
    logic do_pop;

    assign o_stat.full  = (r_cnt == (imu_pkg::Q_AW+1)'(imu_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job  = r_mem[r_rp];
    assign do_pop = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (imu_pkg::Q_AW+1)'(i_push) - (imu_pkg::Q_AW+1)'(do_pop);
        end
    end

endmodule

/* sv/imu_mul.sv */
module imu_mul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic        i_up,
    output logic [63:0] o_p
);

    function automatic logic [5:0] lzc53(input logic [52:0] m);
        logic [5:0] z;
        z = 6'd53;
        for (int i = 0; i < 53; i++) begin
            if (m[i]) z = 6'(52 - i);
        end
        return z;
    endfunction

    // stage 1: specials and leading zero count
    logic        r1_spec, r1_s, r1_away;
    logic [63:0] r1_sval;
    logic [52:0] r1_ma, r1_mb;
    logic [5:0]  r1_za, r1_zb;
    logic signed [13:0] r1_ea, r1_eb;

    logic        n1_spec, n1_s;
    logic [63:0] n1_sval;
    logic [5:0]  n1_za, n1_zb;

    always_comb begin
        n1_s    = i_a[63] ^ i_b[63];
        n1_spec = 1'b1;
        n1_sval = {n1_s, 63'd0};
        if (imu_pkg::is_nan(i_a) || imu_pkg::is_nan(i_b)) begin
            n1_sval = imu_pkg::QNAN_BITS;
        end else if (i_a[62:0] == imu_pkg::INF_BITS[62:0] ||
                     i_b[62:0] == imu_pkg::INF_BITS[62:0]) begin
            if (i_a[62:0] == '0 || i_b[62:0] == '0) n1_sval = imu_pkg::QNAN_BITS;
            else n1_sval = {n1_s, imu_pkg::INF_BITS[62:0]};
        end else if (i_a[62:0] == '0 || i_b[62:0] == '0) begin
            n1_sval = {n1_s, 63'd0};
        end else begin
            n1_spec = 1'b0;
        end
        n1_za = (i_a[62:52] != '0) ? 6'd0 : lzc53({1'b0, i_a[51:0]});
        n1_zb = (i_b[62:52] != '0) ? 6'd0 : lzc53({1'b0, i_b[51:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_spec <= n1_spec;
            r1_sval <= n1_sval;
            r1_s    <= n1_s;
            r1_away <= i_up ^ n1_s;
            r1_ma   <= {i_a[62:52] != '0, i_a[51:0]};
            r1_mb   <= {i_b[62:52] != '0, i_b[51:0]};
            r1_za   <= n1_za;
            r1_zb   <= n1_zb;
            r1_ea   <= (i_a[62:52] != '0) ? $signed({3'b0, i_a[62:52]})
                                          : 14'sd1 - $signed({8'b0, n1_za});
            r1_eb   <= (i_b[62:52] != '0) ? $signed({3'b0, i_b[62:52]})
                                          : 14'sd1 - $signed({8'b0, n1_zb});
        end
    end

    // stage 2: normalize
    logic        r2_spec, r2_s, r2_away;
    logic [63:0] r2_sval;
    logic [52:0] r2_ma, r2_mb;
    logic signed [13:0] r2_esum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_spec <= r1_spec;
            r2_sval <= r1_sval;
            r2_s    <= r1_s;
            r2_away <= r1_away;
            r2_ma   <= r1_ma << r1_za;
            r2_mb   <= r1_mb << r1_zb;
            r2_esum <= r1_ea + r1_eb;
        end
    end

    // stage 3: partial products
    logic        r3_spec, r3_s, r3_away;
    logic [63:0] r3_sval;
    logic signed [13:0] r3_esum;
    logic [53:0] r3_pll;
    logic [52:0] r3_plh, r3_phl;
    logic [51:0] r3_phh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_spec <= r2_spec;
            r3_sval <= r2_sval;
            r3_s    <= r2_s;
            r3_away <= r2_away;
            r3_esum <= r2_esum;
            r3_pll  <= r2_ma[26:0] * r2_mb[26:0];
            r3_plh  <= r2_ma[26:0] * r2_mb[52:27];
            r3_phl  <= r2_ma[52:27] * r2_mb[26:0];
            r3_phh  <= r2_ma[52:27] * r2_mb[52:27];
        end
    end

    // stage 4: sum to full product
    logic        r4_spec, r4_s, r4_away;
    logic [63:0] r4_sval;
    logic signed [13:0] r4_esum;
    logic [105:0] r4_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_spec <= r3_spec;
            r4_sval <= r3_sval;
            r4_s    <= r3_s;
            r4_away <= r3_away;
            r4_esum <= r3_esum;
            r4_p    <= {52'd0, r3_pll} + {26'd0, r3_plh, 27'd0}
                     + {26'd0, r3_phl, 27'd0} + {r3_phh, 54'd0};
        end
    end

    // stage 5: exponent, alignment and sticky
    logic        r5_spec, r5_s, r5_away, r5_ovf, r5_inx;
    logic [63:0] r5_sval;
    logic [10:0] r5_ebits;
    logic [52:0] r5_m;

    logic [6:0]   t;
    logic signed [13:0] e, shw;
    logic         under;
    logic [6:0]   sh;
    logic [127:0] p128, pshr;

    always_comb begin
        t     = r4_p[105] ? 7'd105 : 7'd104;
        e     = r4_esum + $signed({7'b0, t}) - 14'sd1127;
        under = (e < 14'sd1);
        shw   = $signed({7'b0, t}) - 14'sd52 + (under ? (14'sd1 - e) : 14'sd0);
        sh    = (shw > 14'sd127) ? 7'd127 : shw[6:0];
        p128  = {22'd0, r4_p};
        pshr  = p128 >> sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_spec  <= r4_spec;
            r5_sval  <= r4_sval;
            r5_s     <= r4_s;
            r5_away  <= r4_away;
            r5_ovf   <= (e >= 14'sd2047);
            r5_ebits <= under ? 11'd0 : 11'(e - 14'sd1);
            r5_m     <= pshr[52:0];
            r5_inx   <= (p128 << (7'd0 - sh)) != '0;
        end
    end

    // stage 6: round and pack
    logic [63:0] bits, ovf_val, r6_p;

    always_comb begin
        bits    = {1'b0, r5_ebits, 52'd0} + {11'd0, r5_m} + 64'(r5_inx && r5_away);
        ovf_val = {r5_s, r5_away ? imu_pkg::INF_BITS[62:0] : imu_pkg::MAXF_BITS[62:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r5_spec) r6_p <= r5_sval;
            else if (r5_ovf || bits >= imu_pkg::INF_BITS) r6_p <= ovf_val;
            else r6_p <= {r5_s, bits[62:0]};
        end
    end

    assign o_p = r6_p;

endmodule

/* sv/imu_back.sv */
module imu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  imu_pkg::t_job   i_job,
    input  imu_pkg::t_q_stat i_q_stat,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [127:0]    o_data
);

    logic en;
    logic [imu_pkg::MUL_STAGES-1:0] r_vld, r_both;
    logic [63:0] p_lo0, p_lo1, p_hi0, p_hi1;
    logic        r_out_vld;
    logic [127:0] r_out;

    assign en    = !r_out_vld || i_ready;
    assign o_pop = en && !i_q_stat.empty;

    imu_mul u_lo0 (.i_clk, .i_en(en), .i_a(i_job.lo0_a), .i_b(i_job.lo0_b),
                   .i_up(1'b0), .o_p(p_lo0));
    imu_mul u_lo1 (.i_clk, .i_en(en), .i_a(i_job.lo1_a), .i_b(i_job.lo1_b),
                   .i_up(1'b0), .o_p(p_lo1));
    imu_mul u_hi0 (.i_clk, .i_en(en), .i_a(i_job.hi0_a), .i_b(i_job.hi0_b),
                   .i_up(1'b1), .o_p(p_hi0));
    imu_mul u_hi1 (.i_clk, .i_en(en), .i_a(i_job.hi1_a), .i_b(i_job.hi1_b),
                   .i_up(1'b1), .o_p(p_hi1));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_both <= {r_both[imu_pkg::MUL_STAGES-2:0], i_job.both};
            r_out  <= r_both[imu_pkg::MUL_STAGES-1]
                    ? {imu_pkg::fmax_bits(p_hi0, p_hi1), imu_pkg::fmin_bits(p_lo0, p_lo1)}
                    : {p_hi0, p_lo0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[imu_pkg::MUL_STAGES-2:0], !i_q_stat.empty};
            r_out_vld <= r_vld[imu_pkg::MUL_STAGES-1];
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

/* sv/interval_multiply_unit.sv */
// Interval product of two binary64 intervals, lower bound rounded down and upper bound
// rounded up. One item per cycle sustained while the output is accepted; an accepted item
// is written to the queue, then passes from the queue head through six multiplier stages,
// the last of which feeds the min/max output register. A four-entry queue sits in front of the
// multiplier pipeline, which halts as a whole while the output item waits.
module interval_multiply_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,  // a_lower, a_upper, b_lower, b_upper
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // prod_lower, prod_upper
);

    imu_pkg::t_job    job_in, job_head;
    imu_pkg::t_q_stat q_stat;
    logic push, pop;

    imu_front u_front (
        .i_valid(s_axis_tvalid), .i_data(s_axis_tdata), .i_q_stat(q_stat),
        .o_ready(s_axis_tready), .o_push(push), .o_job(job_in)
    );

    imu_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(push), .i_job(job_in), .i_pop(pop),
        .o_job(job_head), .o_stat(q_stat)
    );

    imu_back u_back (
        .i_clk, .i_rst_n, .i_job(job_head), .i_q_stat(q_stat), .o_pop(pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );

endmodule

/* sv/imu_checker.sv */
module imu_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);

    logic [3:0] r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 4'(s_axis_tvalid && s_axis_tready)
                             - 4'(m_axis_tvalid && m_axis_tready);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pend != 4'd0)
        else $error("output item without input");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 4'd11)
        else $error("too many items in flight");

endmodule

bind interval_multiply_unit imu_checker u_imu_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
);

/* sim/interval_multiply_unit_tb.sv */
module interval_multiply_unit_tb;

    localparam logic [63:0] SIGN_M = 64'h8000000000000000;
    localparam logic [63:0] MAG_M  = 64'h7FFFFFFFFFFFFFFF;
    localparam logic [63:0] ONE    = 64'h3FF0000000000000;
    localparam logic [63:0] MINSUB = 64'h0000000000000001;
    localparam int LATENCY = 8;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_bounds;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;   // a_lower, a_upper, b_lower, b_upper
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // prod_lower, prod_upper

    t_bounds exp_bounds_q[$];
    int      n_fail;
    bit      idle_en;

    interval_multiply_unit u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic bit nan_p(logic [63:0] x);
        return (x & MAG_M) > imu_pkg::INF_BITS;
    endfunction

    function automatic bit nonneg(logic [63:0] x);
        return !nan_p(x) && (!x[63] || (x & MAG_M) == 0);
    endfunction

    function automatic bit nonpos(logic [63:0] x);
        return !nan_p(x) && (x[63] || (x & MAG_M) == 0);
    endfunction

    function automatic logic [64:0] rank(logic [63:0] x);
        return x[63] ? {1'b0, ~x} : {1'b0, x | SIGN_M};
    endfunction

    function automatic logic [63:0] lesser(logic [63:0] a, logic [63:0] b);
        if (nan_p(a) || nan_p(b)) return imu_pkg::QNAN_BITS;
        return rank(a) <= rank(b) ? a : b;
    endfunction

    function automatic logic [63:0] greater(logic [63:0] a, logic [63:0] b);
        if (nan_p(a) || nan_p(b)) return imu_pkg::QNAN_BITS;
        return rank(a) >= rank(b) ? a : b;
    endfunction

    // directed-rounding binary64 product
    function automatic logic [63:0] round_mul(logic [63:0] a, logic [63:0] b, bit up);
        logic [63:0]  s, am, bm, m, bits;
        logic [52:0]  ma, mb;
        logic [105:0] p;
        int ea, eb, t, e, sh;
        bit away, inexact;
        s = (a ^ b) & SIGN_M;
        am = a & MAG_M;
        bm = b & MAG_M;
        if (nan_p(a) || nan_p(b)) return imu_pkg::QNAN_BITS;
        if (am == imu_pkg::INF_BITS || bm == imu_pkg::INF_BITS) begin
            if (am == 0 || bm == 0) return imu_pkg::QNAN_BITS;
            return s | imu_pkg::INF_BITS;
        end
        if (am == 0 || bm == 0) return s;
        away = up ? (s == 0) : (s != 0);
        ea = am[62:52];
        ma = {1'b1, am[51:0]};
        if (ea == 0) begin
            ea = 1;
            ma = {1'b0, am[51:0]};
            while (!ma[52]) begin
                ma = ma << 1;
                ea--;
            end
        end
        eb = bm[62:52];
        mb = {1'b1, bm[51:0]};
        if (eb == 0) begin
            eb = 1;
            mb = {1'b0, bm[51:0]};
            while (!mb[52]) begin
                mb = mb << 1;
                eb--;
            end
        end
        p = ma * mb;
        t = p[105] ? 105 : 104;
        e = ea + eb + t - 1127;
        if (e >= 2047) return s | (away ? imu_pkg::INF_BITS : imu_pkg::MAXF_BITS);
        sh = t - 52;
        if (e < 1) begin
            sh += 1 - e;
            e = 0;
        end else begin
            e = e - 1;
        end
        if (sh >= 128) begin
            m = 0;
            inexact = p != 0;
        end else begin
            m = 64'(p >> sh);
            inexact = (p & ((106'd1 << sh) - 1)) != 0;
        end
        bits = (64'(e) << 52) + m;
        if (inexact && away) bits += 1;
        if (bits >= imu_pkg::INF_BITS)
            return s | (away ? imu_pkg::INF_BITS : imu_pkg::MAXF_BITS);
        return s | bits;
    endfunction

    function automatic t_bounds interval_product(logic [63:0] al, logic [63:0] au,
                                                 logic [63:0] bl, logic [63:0] bu);
        t_bounds r;
        if (nonneg(al)) begin
            if (nonneg(bl)) begin
                r.lo = round_mul(al, bl, 0); r.hi = round_mul(au, bu, 1);
            end else if (nonpos(bu)) begin
                r.lo = round_mul(au, bl, 0); r.hi = round_mul(al, bu, 1);
            end else begin
                r.lo = round_mul(au, bl, 0); r.hi = round_mul(au, bu, 1);
            end
        end else if (nonpos(au)) begin
            if (nonneg(bl)) begin
                r.lo = round_mul(al, bu, 0); r.hi = round_mul(au, bl, 1);
            end else if (nonpos(bu)) begin
                r.lo = round_mul(au, bu, 0); r.hi = round_mul(al, bl, 1);
            end else begin
                r.lo = round_mul(al, bu, 0); r.hi = round_mul(al, bl, 1);
            end
        end else begin
            if (nonneg(bl)) begin
                r.lo = round_mul(al, bu, 0); r.hi = round_mul(au, bu, 1);
            end else if (nonpos(bu)) begin
                r.lo = round_mul(au, bl, 0); r.hi = round_mul(al, bl, 1);
            end else begin
                r.lo = lesser(round_mul(au, bl, 0), round_mul(al, bu, 0));
                r.hi = greater(round_mul(al, bl, 1), round_mul(au, bu, 1));
            end
        end
        return r;
    endfunction

    task automatic send_intervals(logic [63:0] al, logic [63:0] au,
                                  logic [63:0] bl, logic [63:0] bu);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bu, bl, au, al};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exp_bounds_q.push_back(interval_product(al, au, bl, bu));
    endtask

    task automatic end_send;
        s_axis_tvalid <= 1'b0;
    endtask

    // result side: random stall bursts
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (idle_en && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_bounds want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (exp_bounds_q.size() == 0) begin
                $display("%0t: unexpected product, actual %h %h", $time, got.lo, got.hi);
                n_fail++;
            end else begin
                want = exp_bounds_q.pop_front();
                if (got.lo !== want.lo) begin
                    $display("%0t: prod_lower expected %h actual %h", $time, want.lo, got.lo);
                    n_fail++;
                end
                if (got.hi !== want.hi) begin
                    $display("%0t: prod_upper expected %h actual %h", $time, want.hi, got.hi);
                    n_fail++;
                end
            end
        end
    end

    function automatic logic [63:0] rand_f64(bit neg);
        logic [63:0] x;
        case ($urandom_range(0, 9))
            0: x = 0;
            1: x = imu_pkg::INF_BITS;
            2: x = {$urandom(), $urandom()} & 64'h000FFFFFFFFFFFFF;
            3: x = {1'b0, 11'(700 + $urandom_range(0, 648)), 20'($urandom()), 32'($urandom())};
            4: x = {1'b0, 11'($urandom_range(0, 100)), 20'($urandom()), 32'($urandom())};
            5: x = imu_pkg::MAXF_BITS - 64'($urandom_range(0, 3));
            default: x = {1'b0, 11'($urandom_range(900, 1150)), 20'($urandom()),
                          32'($urandom())};
        endcase
        return neg ? (x | SIGN_M) : x;
    endfunction

    // ordered interval of a random sign class
    task automatic rand_interval(output logic [63:0] l, output logic [63:0] u);
        logic [63:0] p, q, tmp;
        case ($urandom_range(0, 2))
            0: begin
                p = rand_f64(0); q = rand_f64(0);
                if (p > q) begin tmp = p; p = q; q = tmp; end
                l = p; u = q;
            end
            1: begin
                p = rand_f64(1); q = rand_f64(1);
                if ((p & MAG_M) < (q & MAG_M)) begin tmp = p; p = q; q = tmp; end
                l = p; u = q;
            end
            default: begin
                l = rand_f64(1); u = rand_f64(0);
            end
        endcase
    endtask

    task automatic test_directed;
        logic [63:0] n1;
        n1 = ONE | SIGN_M;
        send_intervals(ONE, ONE << 0 | 64'h0010000000000000, ONE, ONE);
        send_intervals(n1, 0, ONE, ONE);
        send_intervals(0, ONE, n1, SIGN_M);
        send_intervals(n1, ONE, n1, ONE);
        send_intervals(n1, n1, n1, n1);
        send_intervals(n1, ONE, 0, ONE);
        send_intervals(n1, ONE, n1, 0);
        send_intervals(0, 0, imu_pkg::INF_BITS, imu_pkg::INF_BITS);
        send_intervals(SIGN_M, 0, imu_pkg::INF_BITS | SIGN_M, imu_pkg::INF_BITS);
        send_intervals(imu_pkg::MAXF_BITS, imu_pkg::MAXF_BITS, imu_pkg::MAXF_BITS,
                       imu_pkg::MAXF_BITS);
        send_intervals(imu_pkg::MAXF_BITS | SIGN_M, imu_pkg::MAXF_BITS,
                       64'h4000000000000000, 64'h4000000000000000);
        send_intervals(MINSUB, MINSUB, MINSUB, MINSUB);
        send_intervals(MINSUB | SIGN_M, MINSUB, 64'h3FE0000000000000, ONE);
        send_intervals(64'h000FFFFFFFFFFFFF, 64'h000FFFFFFFFFFFFF, 64'h3FEFFFFFFFFFFFFF, ONE);
        send_intervals(imu_pkg::QNAN_BITS, ONE, ONE, ONE);
        send_intervals(n1, imu_pkg::QNAN_BITS, n1, ONE);
        send_intervals(64'hFFFFFFFFFFFFFFFF, 64'h7FFFFFFFFFFFFFFF, n1, ONE);
        send_intervals(ONE, n1, 64'h4000000000000000, SIGN_M);
        send_intervals(64'h3FB999999999999A, 64'h3FB999999999999A, 64'hBFB999999999999A,
                       64'h3FB999999999999A);
        send_intervals(imu_pkg::INF_BITS | SIGN_M, imu_pkg::INF_BITS,
                       imu_pkg::INF_BITS | SIGN_M, imu_pkg::INF_BITS);
        end_send();
    endtask

    task automatic test_random(int count, bit ordered);
        logic [63:0] al, au, bl, bu;
        for (int k = 0; k < count; k++) begin
            if (ordered && $urandom_range(0, 9) != 0) begin
                rand_interval(al, au);
                rand_interval(bl, bu);
            end else begin
                al = {$urandom(), $urandom()}; au = {$urandom(), $urandom()};
                bl = {$urandom(), $urandom()}; bu = {$urandom(), $urandom()};
            end
            send_intervals(al, au, bl, bu);
        end
        end_send();
    endtask

    task automatic drain_results;
        while (exp_bounds_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        n_fail = 0;
        idle_en = 1'b1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain_results();
        test_random(1000, 1);
        drain_results();
        test_random(100, 0);
        idle_en = 1'b0;
        test_random(230, 1);
        drain_results();
        repeat (LATENCY * 4) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
